@@ hdl/bsemb_pkg.sv @@
// ----------------------------------------------------------------------------
// bsemb_pkg
// Shared types and constants of the LSB image steganography embedder.
// ----------------------------------------------------------------------------
`default_nettype none

package bsemb_pkg;

  // Input operation codes
  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_IMAGE = 2'd1,
    OP_NEW   = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MAGIC     = 2'd0,
    REG_EXT_LEN   = 2'd1,
    REG_EXT_CHARS = 2'd2,
    REG_UNUSED    = 2'd3
  } reg_idx_t;

  localparam int unsigned POS_W = 32;

  // Byte offsets of the hidden fields from the start of the image
  localparam logic [POS_W-1:0] HEADER_BYTES = 32'd54;
  localparam logic [POS_W-1:0] LEN_START    = 32'd70;   // after 16 magic bits
  localparam logic [POS_W-1:0] EXT_START    = 32'd102;  // after 32 length bits
  localparam logic [POS_W-1:0] CNT_BITS     = 32'd32;
  localparam logic [2:0]       MAX_EXT_LEN  = 3'd4;

  // Register reset values: "#*" and ".txt"
  localparam logic [15:0] MAGIC_RST     = 16'h2A23;
  localparam logic [2:0]  EXT_LEN_RST   = 3'd4;
  localparam logic [31:0] EXT_CHARS_RST = 32'h7478742E;

  // Stage between layout decode and output register
  typedef struct packed {
    logic       valid;
    logic [7:0] value;
    logic       carry;      // byte carries a hidden bit
    logic       from_store; // hidden bit comes from the secret memory
    logic       dbit;       // hidden bit when taken from a field
    logic [2:0] bit_sel;    // bit of the secret byte
    logic       overflow;
    logic       finished;
  } stg_t;

endpackage : bsemb_pkg

`default_nettype wire

@@ hdl/bsemb_in_if.sv @@
// ----------------------------------------------------------------------------
// bsemb_in_if
// Input channel: operation code and data byte with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsemb_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface : bsemb_in_if

`default_nettype wire

@@ hdl/bsemb_out_if.sv @@
// ----------------------------------------------------------------------------
// bsemb_out_if
// Result channel: image byte with embed and status flags.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsemb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       embedded;
  logic       overflow;
  logic       finished;

  modport source (output valid, output out_byte, output embedded, output overflow,
                  output finished, input ready);
  modport sink   (input valid, input out_byte, input embedded, input overflow,
                  input finished, output ready);
endinterface : bsemb_out_if

`default_nettype wire

@@ hdl/bsemb_cfg_if.sv @@
// ----------------------------------------------------------------------------
// bsemb_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsemb_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface : bsemb_cfg_if

`default_nettype wire

@@ hdl/bmp_lsb_stego_embedder_core.sv @@
// ----------------------------------------------------------------------------
// bmp_lsb_stego_embedder_core
// LSB steganography embedder for a BMP byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   cfg_ch  : register writes (0 magic word, 1 extension length, 2 extension
//             characters); always ready, write only while the block is idle.
//   in_ch   : op 0 loads a secret byte, op 1 is an image byte, op 2 starts a
//             new message, op 3 is ignored. Only op 1 yields a result.
//   out_ch  : one transaction per image byte, with the byte (bit 0 replaced
//             while hidden bits remain), embedded, overflow and finished.
// Path: an image byte is taken into the decode stage register (with the secret
//   memory read), then into the output register.
// Throughput: one transaction per cycle on in_ch unless out_ch stalls; the
//   secret memory has one write and one read port, used by different ops.
// Stall: when out_ch is stalled with a full output register, in_ch.ready drops
//   and the pipeline holds.
// Reset: fill count, image position and overflow flag clear, the registers
//   take their defaults; memory contents are left undefined.
// ----------------------------------------------------------------------------
`default_nettype none

module bmp_lsb_stego_embedder_core #(
  parameter int unsigned SECRET_DEPTH = 128
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  bsemb_in_if.sink    in_ch,
  bsemb_out_if.source out_ch,
  bsemb_cfg_if.sink   cfg_ch
);

  import bsemb_pkg::*;

  localparam int unsigned AW = (SECRET_DEPTH > 1) ? $clog2(SECRET_DEPTH) : 1;
  localparam int unsigned CW = $clog2(SECRET_DEPTH + 1);

  logic [15:0]   magic_r;
  logic [2:0]    ext_len_r;
  logic [31:0]   ext_chars_r;

  logic          advance;
  logic          accept;
  logic          is_load, is_image, is_new;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [CW-1:0] count;
  logic          ovf;
  stg_t          stg;
  logic          hid_bit;

  logic          out_valid_r;
  logic [7:0]    out_byte_r, out_byte_nxt;
  logic          out_emb_r, out_ovf_r, out_fin_r;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r     <= MAGIC_RST;
      ext_len_r   <= EXT_LEN_RST;
      ext_chars_r <= EXT_CHARS_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_MAGIC:     magic_r     <= cfg_ch.data[15:0];
        REG_EXT_LEN:   ext_len_r   <= cfg_ch.data[2:0];
        REG_EXT_CHARS: ext_chars_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Input transaction decode
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;
  assign accept      = in_ch.valid && advance;
  assign is_load     = accept && (in_ch.op == OP_LOAD);
  assign is_image    = accept && (in_ch.op == OP_IMAGE);
  assign is_new      = accept && (in_ch.op == OP_NEW);

  bsemb_store #(
    .SECRET_DEPTH (SECRET_DEPTH),
    .AW           (AW),
    .CW           (CW)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (is_load),
    .clear    (is_new),
    .wr_data  (in_ch.value),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .count    (count),
    .overflow (ovf)
  );

  bsemb_layout #(
    .AW (AW),
    .CW (CW)
  ) u_layout (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .image     (is_image),
    .clear     (is_new),
    .value     (in_ch.value),
    .count     (count),
    .overflow  (ovf),
    .magic     (magic_r),
    .ext_len   (ext_len_r),
    .ext_chars (ext_chars_r),
    .stg       (stg),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  // Merge the hidden bit into the image byte
  assign hid_bit      = stg.from_store ? rd_data[stg.bit_sel] : stg.dbit;
  assign out_byte_nxt = stg.carry ? {stg.value[7:1], hid_bit} : stg.value;

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= stg.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte_r <= out_byte_nxt;
      out_emb_r  <= stg.carry;
      out_ovf_r  <= stg.overflow;
      out_fin_r  <= stg.finished;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.embedded = out_emb_r;
  assign out_ch.overflow = out_ovf_r;
  assign out_ch.finished = out_fin_r;

  // Fill count stays within the memory
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count <= CW'(SECRET_DEPTH))
    else $error("secret count beyond memory depth");

  // Overflow only once the memory is full
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf |-> (count == CW'(SECRET_DEPTH)))
    else $error("overflow flag set with free entries");

  // New message clears count and overflow
  a_new_clears: assert property (@(posedge clk) disable iff (!rst_n)
    is_new |=> (count == '0) && !ovf)
    else $error("new message did not clear state");

  // A stalled result is never overwritten
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |-> !accept)
    else $error("transaction taken while output stalled");

endmodule : bmp_lsb_stego_embedder_core

`default_nettype wire

@@ hdl/bsemb_store.sv @@
// ----------------------------------------------------------------------------
// bsemb_store
// Secret byte memory with fill count and overflow flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bsemb_store #(
  parameter int unsigned SECRET_DEPTH = 128,
  parameter int unsigned AW = 7,
  parameter int unsigned CW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          load,     // secret byte transaction
  input  wire logic          clear,    // new message transaction
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data,
  output logic      [CW-1:0] count,
  output logic               overflow
);

  import bsemb_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(SECRET_DEPTH);

  logic [7:0]    mem_r [SECRET_DEPTH];
  logic [7:0]    rd_data_r;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic          full;
  logic          wr_en;

  assign full  = (count_r == DEPTH_C);
  assign wr_en = load && !full;

  // Advance the fill count, raise overflow on a drop
  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    if (clear) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end else if (load) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Memory: one write port at the fill count, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[count_r[AW-1:0]] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data  = rd_data_r;
  assign count    = count_r;
  assign overflow = ovf_r;

endmodule : bsemb_store

`default_nettype wire

@@ hdl/bsemb_layout.sv @@
// ----------------------------------------------------------------------------
// bsemb_layout
// Image position counter and decode of the hidden field layout.
// ----------------------------------------------------------------------------
`default_nettype none

module bsemb_layout #(
  parameter int unsigned AW = 7,
  parameter int unsigned CW = 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           advance,   // stage may move
  input  wire logic           image,     // image byte transaction
  input  wire logic           clear,     // new message transaction
  input  wire logic [7:0]     value,
  input  wire logic [CW-1:0]  count,
  input  wire logic           overflow,
  input  wire logic [15:0]    magic,
  input  wire logic [2:0]     ext_len,
  input  wire logic [31:0]    ext_chars,
  output bsemb_pkg::stg_t     stg,
  output logic                rd_en,
  output logic [AW-1:0]       rd_addr
);

  import bsemb_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [2:0]       elen;
  logic [POS_W-1:0] cnt32;
  logic [POS_W-1:0] ext_end, cnt_end, sec_end, fin_end;
  logic [POS_W-1:0] k_mag, k_len, k_ext, k_cnt, k_sec;
  logic [POS_W:0]   pos_inc;
  stg_t             stg_r, stg_nxt;

  // Clamp the extension length and place the field boundaries
  assign elen    = (ext_len > MAX_EXT_LEN) ? MAX_EXT_LEN : ext_len;
  assign cnt32   = POS_W'(count);
  assign ext_end = EXT_START + {26'd0, elen, 3'd0};
  assign cnt_end = ext_end + CNT_BITS;
  assign sec_end = cnt_end + {cnt32[POS_W-4:0], 3'd0};
  assign fin_end = sec_end;

  assign k_mag = pos_r - HEADER_BYTES;
  assign k_len = pos_r - LEN_START;
  assign k_ext = pos_r - EXT_START;
  assign k_cnt = pos_r - ext_end;
  assign k_sec = pos_r - cnt_end;

  assign pos_inc = {1'b0, pos_r} + (POS_W+1)'(1);

  // Decode the byte at the current position
  always_comb begin
    stg_nxt          = '0;
    stg_nxt.valid    = image;
    stg_nxt.value    = value;
    stg_nxt.overflow = overflow;
    stg_nxt.finished = (pos_inc >= {1'b0, fin_end});
    rd_en            = 1'b0;
    rd_addr          = k_sec[AW+2:3];
    priority if (pos_r < HEADER_BYTES) begin
      stg_nxt.carry = 1'b0;
    end else if (pos_r < LEN_START) begin
      stg_nxt.carry = 1'b1;
      stg_nxt.dbit  = magic[k_mag[3:0]];
    end else if (pos_r < EXT_START) begin
      stg_nxt.carry = 1'b1;
      stg_nxt.dbit  = (k_len[4:2] == 3'd0 && k_len[1:0] != 2'd3) ? elen[k_len[1:0]] : 1'b0;
    end else if (pos_r < ext_end) begin
      stg_nxt.carry = 1'b1;
      stg_nxt.dbit  = ext_chars[k_ext[4:0]];
    end else if (pos_r < cnt_end) begin
      stg_nxt.carry = 1'b1;
      stg_nxt.dbit  = cnt32[k_cnt[4:0]];
    end else if (pos_r < sec_end) begin
      stg_nxt.carry      = 1'b1;
      stg_nxt.from_store = 1'b1;
      stg_nxt.bit_sel    = k_sec[2:0];
      rd_en              = image;
    end else begin
      stg_nxt.carry = 1'b0;
    end
  end

  // Position: clear on new message, saturate at the top
  always_comb begin
    pos_nxt = pos_r;
    if (clear) begin
      pos_nxt = '0;
    end else if (image && !pos_inc[POS_W]) begin
      pos_nxt = pos_inc[POS_W-1:0];
    end
  end

  // Advance position and stage; hold payload while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      stg_r.valid <= 1'b0;
    end else begin
      pos_r <= pos_nxt;
      if (advance) begin
        stg_r.valid <= stg_nxt.valid;
      end
    end
    if (advance) begin
      stg_r.value      <= stg_nxt.value;
      stg_r.carry      <= stg_nxt.carry;
      stg_r.from_store <= stg_nxt.from_store;
      stg_r.dbit       <= stg_nxt.dbit;
      stg_r.bit_sel    <= stg_nxt.bit_sel;
      stg_r.overflow   <= stg_nxt.overflow;
      stg_r.finished   <= stg_nxt.finished;
    end
  end

  assign stg = stg_r;

endmodule : bsemb_layout

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LSB steganography embedder. A queue of
// operations (secret loads, image bytes, new message, unused op) feeds a
// bursty driver. Every accepted operation runs through a local model of the
// hidden bit layout, and the monitor checks each image byte that comes out
// against the oldest predicted byte. Register settings change between idle
// phases.
// ----------------------------------------------------------------------------
module tb_top;
  import bsemb_pkg::*;

  localparam int unsigned SECRET_DEPTH   = 128;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          PHASES         = 5;

  // Message shapes
  localparam int MSG_SHORT = 0;   // part of the header, at most the first fields
  localparam int MSG_FULL  = 1;   // whole payload and a few bytes past it
  localparam int MSG_GROW  = 2;   // whole payload, secret bytes added mid-stream

  typedef struct packed {
    logic [7:0] out_byte;
    logic       embedded;
    logic       overflow;
    logic       finished;
  } pix_res_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] value;
    logic       drain;   // wait for every pending byte before offering
  } feed_t;

  logic clk = 1'b0;
  logic rst_n;

  bsemb_in_if  in_if ();
  bsemb_out_if out_if ();
  bsemb_cfg_if cfg_if ();

  bmp_lsb_stego_embedder_core #(
    .SECRET_DEPTH(SECRET_DEPTH)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the registers and the embedder state
  logic [15:0] magic_r;
  logic [2:0]  extlen_r;
  logic [31:0] extch_r;
  logic [7:0]  secret_mem [SECRET_DEPTH];
  int unsigned secret_cnt = 0;
  logic [31:0] img_pos    = '0;
  bit          ovf_flag   = 1'b0;

  feed_t    byte_feed_q [$];
  pix_res_t stego_bytes_q [$];

  int items_queued  = 0;
  int items_taken   = 0;
  int results_due   = 0;
  int results_seen  = 0;
  int fails         = 0;
  int burst_left    = 0;
  int gap_left      = 0;
  int hold_off      = 0;
  bit long_done     = 1'b0;
  int rx_cyc        = 0;
  int rx_mode       = 0;
  int idle_cyc      = 0;

  // Apply one operation to the local state; returns 1 when it yields a byte
  function automatic bit embed_step(input op_t op, input logic [7:0] val,
                                    output pix_res_t res);
    longint unsigned elen, total, pos, off, body;
    logic [63:0]     field;
    int unsigned     sh;
    bit              carry;
    res = '0;
    case (op)
      OP_LOAD: begin
        if (secret_cnt < SECRET_DEPTH) begin
          secret_mem[secret_cnt] = val;
          secret_cnt++;
        end else begin
          ovf_flag = 1'b1;
        end
        return 1'b0;
      end
      OP_NEW: begin
        secret_cnt = 0;
        img_pos    = '0;
        ovf_flag   = 1'b0;
        return 1'b0;
      end
      OP_IMAGE: ;
      default: return 1'b0;
    endcase
    elen  = 64'((extlen_r > MAX_EXT_LEN) ? MAX_EXT_LEN : extlen_r);
    total = 64'd80 + 64'd8 * elen + 64'd8 * 64'(secret_cnt);
    pos   = 64'(img_pos);
    field = '0;
    sh    = 0;
    carry = 1'b0;
    // Pick the hidden field and bit for this payload offset
    if (pos >= 64'(HEADER_BYTES)) begin
      off   = pos - 64'(HEADER_BYTES);
      body  = off - 64'd80 - 64'd8 * elen;
      carry = 1'b1;
      if (off < 64'd16) begin
        field = 64'(magic_r);
        sh    = 32'(off);
      end else if (off < 64'd48) begin
        field = elen;
        sh    = 32'(off - 64'd16);
      end else if (off < 64'd48 + 64'd8 * elen) begin
        field = 64'(extch_r);
        sh    = 32'(off - 64'd48);
      end else if (off < 64'd80 + 64'd8 * elen) begin
        field = 64'(secret_cnt);
        sh    = 32'(off - 64'd48 - 64'd8 * elen);
      end else if (off < total) begin
        field = 64'(secret_mem[body >> 3]);
        sh    = 32'(body & 64'd7);
      end else begin
        carry = 1'b0;
      end
    end
    res.out_byte = carry ? {val[7:1], field[sh]} : val;
    res.embedded = carry;
    res.overflow = ovf_flag;
    res.finished = (pos + 64'd1) >= (64'(HEADER_BYTES) + total);
    if (img_pos != 32'hFFFF_FFFF) img_pos++;
    return 1'b1;
  endfunction

  // Driver: bursts of transactions with random gaps
  always @(posedge clk) begin
    pix_res_t res;
    feed_t    nxt;
    int       due;
    bit       may_send;
    due = results_due;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        items_taken <= items_taken + 1;
        if (embed_step(op_t'(in_if.op), in_if.value, res)) begin
          stego_bytes_q.push_back(res);
          due++;
        end
      end
      if (!(in_if.valid && !in_if.ready)) begin
        may_send = (gap_left == 0) && (byte_feed_q.size() > 0);
        if (may_send && byte_feed_q[0].drain && due != results_seen) may_send = 1'b0;
        if (may_send) begin
          nxt = byte_feed_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.op    <= nxt.op;
          in_if.value <= nxt.value;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
          end
        end else begin
          in_if.valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
    end
    results_due <= due;
  end

  // Monitor: check each output transaction and drive the stall pattern
  always @(posedge clk) begin
    pix_res_t want;
    pix_res_t got;
    bit       rdy;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        got = '{out_byte: out_if.out_byte, embedded: out_if.embedded,
                overflow: out_if.overflow, finished: out_if.finished};
        if (stego_bytes_q.size() == 0) begin
          $error("unexpected output byte %0h", got.out_byte);
          fails++;
        end else begin
          want = stego_bytes_q.pop_front();
          if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            fails++;
          end
          if (got.embedded !== want.embedded) begin
            $error("embedded: expected %0b, got %0b", want.embedded, got.embedded);
            fails++;
          end
          if (got.overflow !== want.overflow) begin
            $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
            fails++;
          end
          if (got.finished !== want.finished) begin
            $error("finished: expected %0b, got %0b", want.finished, got.finished);
            fails++;
          end
        end
      end
      rx_cyc++;
      if (rx_cyc % 97 == 0) rx_mode = $urandom_range(0, 3);
      // Hold off once for a long stretch while the queue is well stocked
      if (!long_done && results_seen >= 50 && byte_feed_q.size() > 64) begin
        long_done = 1'b1;
        hold_off  = 60;
      end
      case (rx_mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = (rx_cyc % 4 == 0);
        default: rdy = ($urandom_range(0, 7) != 0);
      endcase
      if (hold_off > 0) begin
        hold_off--;
        rdy = 1'b0;
      end
      out_if.ready <= rdy;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cyc <= 0;
    end else if (idle_cyc >= WATCHDOG_LIMIT) begin
      $display("bmp_lsb_stego_embedder_core test failed");
      $finish;
    end else begin
      idle_cyc <= idle_cyc + 1;
    end
  end

  task automatic push_item(input op_t op, input logic [7:0] val, input bit drain = 1'b0);
    byte_feed_q.push_back('{op: op, value: val, drain: drain});
    items_queued++;
  endtask

  // Write one register; the caller lowers valid after the last write
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= d;
    do @(posedge clk); while (!cfg_if.ready);
    case (idx)
      REG_MAGIC:     magic_r  = d[15:0];
      REG_EXT_LEN:   extlen_r = d[2:0];
      REG_EXT_CHARS: extch_r  = d;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] m, input logic [2:0] len,
                           input logic [31:0] chars, input bit touch_unused);
    write_reg(REG_MAGIC, {16'h0, m});
    write_reg(REG_EXT_LEN, {29'h0, len});
    write_reg(REG_EXT_CHARS, chars);
    if (touch_unused) write_reg(REG_UNUSED, $urandom);
    cfg_if.valid <= 1'b0;
  endtask

  // Wait until all queued transactions are taken and all bytes are back
  task automatic wait_idle();
    do @(posedge clk);
    while (!(items_taken == items_queued && results_seen == results_due));
    repeat (5) @(posedge clk);
  endtask

  // One message: new, secret loads, then the image stream (more loads mid-stream in the grow shape)
  task automatic add_message(input int n_load, input bit drain, input int mode);
    int elen, stream_len, mid_loads;
    elen      = int'((extlen_r > MAX_EXT_LEN) ? MAX_EXT_LEN : extlen_r);
    mid_loads = 0;
    push_item(OP_NEW, 8'($urandom), drain);
    for (int i = 0; i < n_load; i++) push_item(OP_LOAD, 8'($urandom));
    if (mode == MSG_SHORT) begin
      stream_len = int'($urandom_range(16, 80));
    end else begin
      stream_len = int'(HEADER_BYTES) + 80 + 8 * elen + 8 * n_load +
                   int'($urandom_range(0, 8));
    end
    for (int i = 0; i < stream_len; i++) begin
      if ($urandom_range(0, 39) == 0) push_item(OP_NONE, 8'($urandom));
      // Append secret bytes while the image is streaming; stretch the image to match
      if (mode == MSG_GROW && n_load + mid_loads < SECRET_DEPTH &&
          $urandom_range(0, 59) == 0) begin
        push_item(OP_LOAD, 8'($urandom));
        mid_loads++;
        stream_len += 8;
      end
      push_item(OP_IMAGE, 8'($urandom));
    end
  endtask

  task automatic add_noise();
    int n;
    n = $urandom_range(4, 16);
    for (int i = 0; i < n; i++) push_item(op_t'($urandom_range(0, 3)), 8'($urandom));
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_MAGIC;
    cfg_if.data  = 32'h0;
    rst_n        = 1'b0;
    magic_r    = MAGIC_RST;
    extlen_r   = EXT_LEN_RST;
    extch_r    = EXT_CHARS_RST;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: header extremes, unused op, loads, new message mid-stream
    push_item(OP_IMAGE, 8'h00);
    push_item(OP_IMAGE, 8'hFF);
    push_item(OP_NONE, 8'h5A);
    push_item(OP_LOAD, 8'hFF);
    push_item(OP_LOAD, 8'h00);
    push_item(OP_IMAGE, 8'hA5);
    push_item(OP_LOAD, 8'h81);
    push_item(OP_NEW, 8'hFF);
    push_item(OP_IMAGE, 8'hFF);
    push_item(OP_LOAD, 8'h7E);
    push_item(OP_IMAGE, 8'h3C);
    push_item(OP_NEW, 8'h00);
    push_item(OP_NONE, 8'hFF);
    push_item(OP_IMAGE, 8'h00);
    wait_idle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: ;
        1: configure(16'h0000, 3'd0, 32'h0000_0000, 1'b0);
        2: configure(16'hFFFF, 3'd7, 32'hFFFF_FFFF, 1'b0);
        3: configure(16'($urandom), 3'($urandom_range(1, 3)), $urandom, 1'b1);
        default: configure(16'($urandom), 3'($urandom_range(4, 6)), $urandom, 1'b0);
      endcase
      case (ph)
        1: add_message(int'($urandom_range(0, 4)), 1'b1, MSG_FULL);
        // Fill the store past its depth, then stream part of the header, at most the first fields
        2: add_message(int'(SECRET_DEPTH) + 2, 1'b1, MSG_SHORT);
        4: add_message(int'($urandom_range(0, 4)), 1'b1, MSG_GROW);
        default: add_message(int'($urandom_range(0, 4)), 1'b1, MSG_SHORT);
      endcase
      if (ph == 3) begin
        add_message(int'($urandom_range(0, 4)), 1'b1, MSG_SHORT);
        add_noise();
      end
      wait_idle();
    end

    repeat (10) @(posedge clk);
    if (fails == 0 && stego_bytes_q.size() == 0) begin
      $display("bmp_lsb_stego_embedder_core test passed");
    end else begin
      $display("bmp_lsb_stego_embedder_core test failed");
    end
    $finish;
  end

endmodule : tb_top
